FILE: src/pl3d_pkg.sv
// ----------------------------------------------------------------------------
// pl3d_pkg: shared types and constants for the periodic 3D Laplacian
// Field widths, fixed-point formats and the control word of the MAC unit.
// ----------------------------------------------------------------------------
package pl3d_pkg;

  // field and register widths
  localparam int CELL_W  = 18;   // signed Q1.16 cell value
  localparam int INV_W   = 24;   // unsigned Q16.8 inverse spacing squared
  localparam int SIZE_W  = 6;    // axis size register
  localparam int COORD_W = 6;    // internal coordinate, holds size - 1
  localparam int IDX_W   = 5;    // coordinate field of an input word
  localparam int CFG_W   = 24;   // config write data
  localparam int CFG_IDX_W = 3;
  localparam int LAP_W   = 40;   // saturated result

  // datapath widths
  localparam int E_W     = 20;   // neighbor sum minus twice the center
  localparam int PROD_W  = E_W + INV_W + 1;
  localparam int ACC_W   = 48;
  localparam int FRAC_SHIFT = 8; // Q.24 terms down to Q.16

  // axis size limits
  localparam int SIZE_CAP = 63;
  localparam int MIN_SIZE = 2;

  // reset values of the config registers
  localparam logic [SIZE_W-1:0] SIZE_RST = 6'd32;
  localparam logic [INV_W-1:0]  INV_RST  = 24'd1048576;

  localparam logic [LAP_W-1:0] LAP_MAX = {1'b0, {(LAP_W-1){1'b1}}};
  localparam logic [LAP_W-1:0] LAP_MIN = {1'b1, {(LAP_W-1){1'b0}}};

  typedef logic signed [CELL_W-1:0] cell_t;
  typedef logic [INV_W-1:0]         inv_t;
  typedef logic [COORD_W-1:0]       coord_t;
  typedef coord_t [2:0]             coord3_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // control word from the sequencer to the MAC unit, one per read word
  typedef struct packed {
    logic  clear;   // zero the accumulator
    logic  center;  // read word is the center cell
    logic  first;   // first neighbor of an axis
    logic  second;  // second neighbor, axis term is complete
    axis_t axis;
  } mac_ctrl_t;

endpackage

FILE: src/pl3d_wrap.sv
// ----------------------------------------------------------------------------
// pl3d_wrap: iterative remainder unit
// Reduces three coordinates modulo their axis sizes, one restoring
// compare-subtract step per cycle, all three axes side by side.
// ----------------------------------------------------------------------------
module pl3d_wrap import pl3d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  coord3_t modulus,
  input  coord3_t value,
  output coord3_t rem,
  output logic    done
);

  localparam int DVS_W  = COORD_W + IDX_W;
  localparam int STEP_W = $clog2(IDX_W);

  logic              run;
  logic [STEP_W-1:0] step;
  coord3_t           rem_next;

  // one restoring step: subtract modulus << k when it fits
  function automatic coord_t rem_step(coord_t r, coord_t m, logic [STEP_W-1:0] k);
    logic [DVS_W-1:0] rw;
    logic [DVS_W-1:0] d;
    rw = DVS_W'(r);
    d  = DVS_W'(m) << k;
    return (rw >= d) ? COORD_W'(rw - d) : r;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_next[i] = rem_step(rem[i], modulus[i], step);
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= STEP_W'(IDX_W - 1);
      end else if (run) begin
        if (step == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // partial remainders; held after the last step
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= value;
    end else if (run) begin
      rem <= rem_next;
    end
  end

endmodule

FILE: src/pl3d_grid_ram.sv
// ----------------------------------------------------------------------------
// pl3d_grid_ram: single-port grid memory
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module pl3d_grid_ram import pl3d_pkg::*; #(
  parameter  int DEPTH  = 32768,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  cell_t             wdata,
  output cell_t             rdata
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: src/pl3d_mac.sv
// ----------------------------------------------------------------------------
// pl3d_mac: shared multiply-accumulate unit
// Builds each axis term from the read words, multiplies it by the axis
// inverse spacing squared and accumulates the three products.
// ----------------------------------------------------------------------------
module pl3d_mac import pl3d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mac_ctrl_t ctrl,
  input  cell_t     rd_data,
  input  inv_t      inv_x,
  input  inv_t      inv_y,
  input  inv_t      inv_z,
  output acc_t      acc
);

  cell_t                    center;
  logic signed [E_W-1:0]    term;
  logic signed [E_W-1:0]    data_ext;
  logic signed [E_W-1:0]    center_x2;
  logic                     mul_go;
  axis_t                    mul_axis;
  inv_t                     inv_sel;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;

  assign data_ext  = $signed({{(E_W-CELL_W){rd_data[CELL_W-1]}}, rd_data});
  assign center_x2 = $signed({{(E_W-CELL_W-1){center[CELL_W-1]}}, center, 1'b0});

  // inverse spacing of the axis being multiplied
  always_comb begin
    unique case (mul_axis)
      AXIS_X:  inv_sel = inv_x;
      AXIS_Y:  inv_sel = inv_y;
      AXIS_Z:  inv_sel = inv_z;
      default: inv_sel = inv_x;
    endcase
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_go   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      mul_go   <= ctrl.second;
      prod_vld <= mul_go;
    end
  end

  // axis term, product, accumulator
  always_ff @(posedge clk) begin
    if (ctrl.center) begin
      center <= rd_data;
    end
    if (ctrl.first) begin
      term <= data_ext - center_x2;
    end else if (ctrl.second) begin
      term <= term + data_ext;
    end
    if (ctrl.second) begin
      mul_axis <= ctrl.axis;
    end
    prod <= term * $signed({1'b0, inv_sel});
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
    end
  end

endmodule

FILE: src/periodic_laplacian_3d_top.sv
// ----------------------------------------------------------------------------
// periodic_laplacian_3d_top: 7-point Laplacian on a periodic 3D grid
//
// Command channel: a word is taken at a clock edge with start high and busy
// low. opcode 0 writes cell_value into the cell at (x, y, z); opcode 1 asks
// for the Laplacian at that cell. Coordinates wrap modulo the axis sizes.
// Result channel: done is high for one cycle with laplacian and saturated;
// a load gives no result. The receiver cannot stall, so a result must be
// taken in the cycle it is shown.
// Sequence: a command keeps busy high while the remainder unit wraps the
// coordinates; a load ends there. A query then reads the center and six
// neighbors through the single grid memory port, then multiplies,
// accumulates and rounds, with done in the first cycle with busy low.
// A new command may be taken in the cycle done is shown.
// Config port: cfg_we writes cfg_data into register cfg_index at once;
// write only while busy is low.
// Reset: sizes go to 32 and inverse spacings to 4096.0; the grid memory is
// not cleared and a cell must be loaded before it is queried.
// ----------------------------------------------------------------------------
module periodic_laplacian_3d_top import pl3d_pkg::*; #(
  parameter int NX_MAX = 32,
  parameter int NY_MAX = 32,
  parameter int NZ_MAX = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  logic                   opcode,
  input  logic [IDX_W-1:0]       x_index,
  input  logic [IDX_W-1:0]       y_index,
  input  logic [IDX_W-1:0]       z_index,
  input  logic signed [CELL_W-1:0] cell_value,
  // result channel
  output logic                   done,
  output logic signed [LAP_W-1:0] laplacian,
  output logic                   saturated,
  // config port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int DEPTH  = NX_MAX * NY_MAX * NZ_MAX;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam coord_t NX_CAP = COORD_W'((NX_MAX > SIZE_CAP) ? SIZE_CAP : NX_MAX);
  localparam coord_t NY_CAP = COORD_W'((NY_MAX > SIZE_CAP) ? SIZE_CAP : NY_MAX);
  localparam coord_t NZ_CAP = COORD_W'((NZ_MAX > SIZE_CAP) ? SIZE_CAP : NZ_MAX);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_X_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DZ = 3'd5;

  localparam int WAIT_CYCLES = 4;
  localparam logic [1:0] WAIT_LAST = 2'(WAIT_CYCLES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_READ,
    S_WAIT
  } state_t;

  // read order: center, then both neighbors of each axis
  typedef enum logic [2:0] {
    TAP_C,
    TAP_XP,
    TAP_XM,
    TAP_YP,
    TAP_YM,
    TAP_ZP,
    TAP_ZM
  } tap_t;

  state_t      state;
  tap_t        tap_q;
  tap_t        rd_tap_q;
  logic        rd_vld_q;
  logic [1:0]  wait_cnt;
  logic        op_q;
  cell_t       value_q;

  coord_t      x_size, y_size, z_size;
  inv_t        inv_dx_sq, inv_dy_sq, inv_dz_sq;
  coord_t      nx, ny, nz;

  logic        accept;
  coord3_t     mod_size;
  coord3_t     mod_value;
  coord3_t     pos;
  logic        mod_done;

  coord_t      ax, ay, az;
  logic        ram_we;
  logic [ADDR_W-1:0] ram_addr;
  cell_t       ram_rdata;

  mac_ctrl_t   mac_ctrl;
  acc_t        acc;
  acc_t        acc_sh;
  logic        ovf;

  function automatic coord_t clamp_size(coord_t s, coord_t cap);
    if (s < COORD_W'(MIN_SIZE)) return COORD_W'(MIN_SIZE);
    if (s > cap) return cap;
    return s;
  endfunction

  function automatic coord_t wrap_up(coord_t v, coord_t n);
    return (v == n - 1'b1) ? '0 : v + 1'b1;
  endfunction

  function automatic coord_t wrap_dn(coord_t v, coord_t n);
    return (v == '0) ? n - 1'b1 : v - 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(coord_t x, coord_t y, coord_t z);
    logic [31:0] a;
    a = (32'(x) * 32'(NY_MAX) + 32'(y)) * 32'(NZ_MAX) + 32'(z);
    return a[ADDR_W-1:0];
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_size    <= SIZE_RST;
      y_size    <= SIZE_RST;
      z_size    <= SIZE_RST;
      inv_dx_sq <= INV_RST;
      inv_dy_sq <= INV_RST;
      inv_dz_sq <= INV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_SIZE: x_size    <= cfg_data[SIZE_W-1:0];
        REG_Y_SIZE: y_size    <= cfg_data[SIZE_W-1:0];
        REG_Z_SIZE: z_size    <= cfg_data[SIZE_W-1:0];
        REG_INV_DX: inv_dx_sq <= cfg_data[INV_W-1:0];
        REG_INV_DY: inv_dy_sq <= cfg_data[INV_W-1:0];
        REG_INV_DZ: inv_dz_sq <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes in use
  assign nx = clamp_size(x_size, NX_CAP);
  assign ny = clamp_size(y_size, NY_CAP);
  assign nz = clamp_size(z_size, NZ_CAP);

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // coordinate wrap
  assign mod_size  = {nz, ny, nx};
  assign mod_value = {COORD_W'(z_index), COORD_W'(y_index), COORD_W'(x_index)};

  pl3d_wrap u_wrap (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .modulus (mod_size),
    .value   (mod_value),
    .rem     (pos),
    .done    (mod_done)
  );

  // cell selected by the current tap
  always_comb begin
    ax = pos[0];
    ay = pos[1];
    az = pos[2];
    unique case (tap_q)
      TAP_C:   ;
      TAP_XP:  ax = wrap_up(pos[0], nx);
      TAP_XM:  ax = wrap_dn(pos[0], nx);
      TAP_YP:  ay = wrap_up(pos[1], ny);
      TAP_YM:  ay = wrap_dn(pos[1], ny);
      TAP_ZP:  az = wrap_up(pos[2], nz);
      TAP_ZM:  az = wrap_dn(pos[2], nz);
      default: ;
    endcase
  end

  assign ram_addr = cell_addr(ax, ay, az);
  assign ram_we   = (state == S_MOD) && mod_done && (op_q == OP_LOAD);

  pl3d_grid_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (value_q),
    .rdata (ram_rdata)
  );

  // MAC control from the tap of the word now on the read port
  always_comb begin
    mac_ctrl        = '0;
    mac_ctrl.axis   = AXIS_X;
    mac_ctrl.clear  = (state == S_MOD) && mod_done && (op_q == OP_QUERY);
    if (rd_vld_q) begin
      unique case (rd_tap_q)
        TAP_C:   mac_ctrl.center = 1'b1;
        TAP_XP:  mac_ctrl.first  = 1'b1;
        TAP_XM:  mac_ctrl.second = 1'b1;
        TAP_YP:  mac_ctrl.first  = 1'b1;
        TAP_YM:  mac_ctrl.second = 1'b1;
        TAP_ZP:  mac_ctrl.first  = 1'b1;
        TAP_ZM:  mac_ctrl.second = 1'b1;
        default: ;
      endcase
      unique case (rd_tap_q)
        TAP_YP, TAP_YM: mac_ctrl.axis = AXIS_Y;
        TAP_ZP, TAP_ZM: mac_ctrl.axis = AXIS_Z;
        default:        mac_ctrl.axis = AXIS_X;
      endcase
    end
  end

  pl3d_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mac_ctrl),
    .rd_data (ram_rdata),
    .inv_x   (inv_dx_sq),
    .inv_y   (inv_dy_sq),
    .inv_z   (inv_dz_sq),
    .acc     (acc)
  );

  // floor shift to Q.16 and 40-bit saturation
  assign acc_sh = acc >>> FRAC_SHIFT;
  assign ovf    = !((&acc_sh[ACC_W-1:LAP_W-1]) || !(|acc_sh[ACC_W-1:LAP_W-1]));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_vld_q <= (state == S_READ);
      rd_tap_q <= tap_q;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q    <= opcode;
            value_q <= cell_value;
            tap_q   <= TAP_C;
            state   <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= (op_q == OP_QUERY) ? S_READ : S_IDLE;
          end
        end
        S_READ: begin
          if (tap_q == TAP_ZM) begin
            wait_cnt <= '0;
            state    <= S_WAIT;
          end else begin
            tap_q <= tap_t'(tap_q + 3'd1);
          end
        end
        S_WAIT: begin
          if (wait_cnt == WAIT_LAST) begin
            laplacian <= ovf ? (acc_sh[ACC_W-1] ? LAP_MIN : LAP_MAX)
                             : acc_sh[LAP_W-1:0];
            saturated <= ovf;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            wait_cnt <= wait_cnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result never overlaps a command in progress
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // a result only follows the accumulate wait of a query
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state == S_WAIT) && $past(op_q == OP_QUERY)))
    else $error("result strobe without a finished query");

  // an accepted command always starts the sequencer
  a_accept: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted command did not start");

  // the remainder unit finishes only while the sequencer waits on it
  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("remainder done outside wrap phase");
`endif

endmodule

FILE: bench/tb_periodic_laplacian_3d_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_laplacian_3d_top: self-checking bench for the periodic 3D
// Laplacian
// A planner fills a queue of command words, register writes and idle holds.
// A clocked driver plays them onto the command and config ports, and a
// clocked monitor checks each result word against a bit-exact predictor.
// Every query touches only cells that were loaded, under the sizes in force.
// ----------------------------------------------------------------------------
module tb_periodic_laplacian_3d_top;
  import pl3d_pkg::*;

  localparam int NX = 32;
  localparam int NY = 32;
  localparam int NZ = 32;
  localparam int GRID_CELLS = NX * NY * NZ;
  localparam int IDX_TOP = (1 << IDX_W) - 1;
  localparam int SETTLE_CYC = 24;     // idle cycles before a register write
  localparam int TAIL_CYC = 40;       // quiet time after the last result
  localparam int DRAIN_CYC = 4000;    // bound on the final wait for results
  localparam int PHASE_WORDS = 100;
  localparam int TIMEOUT_NS = 5000000;

  localparam cell_t CELL_MAX = {1'b0, {(CELL_W-1){1'b1}}};
  localparam cell_t CELL_MIN = {1'b1, {(CELL_W-1){1'b0}}};
  localparam inv_t INV_MAX = '1;
  localparam longint LAP_HI = 64'sd549755813887;
  localparam longint LAP_LO = -64'sd549755813888;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_SIZE,
    REG_Y_SIZE,
    REG_Z_SIZE,
    REG_INV_DX,
    REG_INV_DY,
    REG_INV_DZ
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STEP_WORD,
    STEP_HOLD,
    STEP_REG
  } step_kind_t;

  typedef struct {
    step_kind_t       kind;
    op_t              op;
    logic [IDX_W-1:0] xi;
    logic [IDX_W-1:0] yi;
    logic [IDX_W-1:0] zi;
    cell_t            val;
    cfg_reg_t         ridx;
    logic [CFG_W-1:0] wdata;
    int               gap_pct;
  } plan_step_t;

  typedef struct {
    logic [LAP_W-1:0] lap;
    logic             sat;
  } lap_result_t;

  // ports
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    opcode = 1'b0;
  logic [IDX_W-1:0]        x_index = '0;
  logic [IDX_W-1:0]        y_index = '0;
  logic [IDX_W-1:0]        z_index = '0;
  cell_t                   cell_value = '0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    busy;
  logic                    done;
  logic signed [LAP_W-1:0] laplacian;
  logic                    saturated;

  // predictor state
  logic [SIZE_W-1:0] size_reg [3];
  inv_t              inv_reg [3];
  cell_t             grid_model [GRID_CELLS];
  lap_result_t       lap_pending [$];

  // planner state, runs ahead of the driver
  plan_step_t  cmd_plan [$];
  int unsigned plan_n [3];
  bit          plan_loaded [GRID_CELLS];
  int          plan_gap;
  int          plan_words;
  int          plan_settings;

  int settle_cnt;
  int n_loads, n_queries, n_checked, n_cfg, n_fail, n_mismatch;

  periodic_laplacian_3d_top #(
    .NX_MAX(NX),
    .NY_MAX(NY),
    .NZ_MAX(NZ)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .x_index(x_index),
    .y_index(y_index),
    .z_index(z_index),
    .cell_value(cell_value),
    .done(done),
    .laplacian(laplacian),
    .saturated(saturated),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned axis_top(int k);
    case (k)
      0: return NX;
      1: return NY;
      default: return NZ;
    endcase
  endfunction

  // size register as the block uses it
  function automatic int unsigned eff_size(logic [SIZE_W-1:0] s, int unsigned top);
    if (s < MIN_SIZE) return MIN_SIZE;
    if (s > top) return top;
    return s;
  endfunction

  function automatic int unsigned cell_addr(int unsigned x, int unsigned y, int unsigned z);
    return (x * NY + y) * NZ + z;
  endfunction

  // predictor: one accepted command word
  task automatic apply_word(op_t op, logic [IDX_W-1:0] xi, logic [IDX_W-1:0] yi,
                            logic [IDX_W-1:0] zi, cell_t v);
    int unsigned n [3];
    int unsigned c [3];
    int unsigned up [3];
    int unsigned dn [3];
    longint ctr2, acc, r;
    lap_result_t res;
    for (int k = 0; k < 3; k++) n[k] = eff_size(size_reg[k], axis_top(k));
    c[0] = xi % n[0];
    c[1] = yi % n[1];
    c[2] = zi % n[2];
    if (op == OP_LOAD) begin
      grid_model[cell_addr(c[0], c[1], c[2])] = v;
      n_loads++;
    end else begin
      ctr2 = 2 * longint'(grid_model[cell_addr(c[0], c[1], c[2])]);
      acc = 0;
      // per axis: neighbor sum minus twice the center, times inverse spacing
      for (int k = 0; k < 3; k++) begin
        up = c;
        dn = c;
        up[k] = (c[k] + 1) % n[k];
        dn[k] = (c[k] + n[k] - 1) % n[k];
        acc += (longint'(grid_model[cell_addr(up[0], up[1], up[2])])
              + longint'(grid_model[cell_addr(dn[0], dn[1], dn[2])]) - ctr2)
              * longint'(inv_reg[k]);
      end
      r = acc >>> FRAC_SHIFT;   // floor toward minus infinity
      res.sat = 1'b0;
      if (r > LAP_HI) begin
        r = LAP_HI;
        res.sat = 1'b1;
      end else if (r < LAP_LO) begin
        r = LAP_LO;
        res.sat = 1'b1;
      end
      res.lap = r[LAP_W-1:0];
      lap_pending.insert(lap_pending.size(), res);
      n_queries++;
    end
  endtask

  task automatic apply_reg(cfg_reg_t ridx, logic [CFG_W-1:0] d);
    case (ridx)
      REG_X_SIZE: size_reg[0] = d[SIZE_W-1:0];
      REG_Y_SIZE: size_reg[1] = d[SIZE_W-1:0];
      REG_Z_SIZE: size_reg[2] = d[SIZE_W-1:0];
      REG_INV_DX: inv_reg[0] = d[INV_W-1:0];
      REG_INV_DY: inv_reg[1] = d[INV_W-1:0];
      REG_INV_DZ: inv_reg[2] = d[INV_W-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  // ---- planner helpers ----

  task automatic push_step(step_kind_t kind, op_t op, int unsigned x, int unsigned y,
                           int unsigned z, cell_t v, cfg_reg_t ridx,
                           logic [CFG_W-1:0] d);
    plan_step_t s;
    s.kind = kind;
    s.op = op;
    s.xi = x[IDX_W-1:0];
    s.yi = y[IDX_W-1:0];
    s.zi = z[IDX_W-1:0];
    s.val = v;
    s.ridx = ridx;
    s.wdata = d;
    s.gap_pct = plan_gap;
    cmd_plan.insert(cmd_plan.size(), s);
    if (kind == STEP_WORD) plan_words++;
  endtask

  // sender waits until every result is in and the block has gone quiet
  task automatic push_hold();
    push_step(STEP_HOLD, OP_LOAD, 0, 0, 0, '0, REG_X_SIZE, '0);
  endtask

  task automatic push_load(int unsigned x, int unsigned y, int unsigned z, cell_t v);
    plan_loaded[cell_addr(x % plan_n[0], y % plan_n[1], z % plan_n[2])] = 1'b1;
    push_step(STEP_WORD, OP_LOAD, x, y, z, v, REG_X_SIZE, '0);
  endtask

  function automatic cell_t rand_cell();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(7))
      0: return CELL_MAX;
      1: return CELL_MIN;
      2: return '0;
      default: return w[CELL_W-1:0];
    endcase
  endfunction

  // any raw index that wraps to w under size n
  function automatic int unsigned raw_index(int unsigned w, int unsigned n);
    return w + $urandom_range((IDX_TOP - w) / n) * n;
  endfunction

  // load whatever part of the 7-point stencil is still unwritten, then query
  task automatic push_query(int unsigned x, int unsigned y, int unsigned z);
    int unsigned c [3];
    int unsigned nb [3];
    int k;
    c[0] = x % plan_n[0];
    c[1] = y % plan_n[1];
    c[2] = z % plan_n[2];
    for (int j = 0; j < 7; j++) begin
      nb = c;
      if (j > 0) begin
        k = (j - 1) / 2;
        nb[k] = (j % 2) ? (c[k] + 1) % plan_n[k] : (c[k] + plan_n[k] - 1) % plan_n[k];
      end
      if (!plan_loaded[cell_addr(nb[0], nb[1], nb[2])])
        push_load(raw_index(nb[0], plan_n[0]), raw_index(nb[1], plan_n[1]),
                  raw_index(nb[2], plan_n[2]), rand_cell());
    end
    push_step(STEP_WORD, OP_QUERY, x, y, z, rand_cell(), REG_X_SIZE, '0);
  endtask

  task automatic push_cfg(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                          logic [SIZE_W-1:0] sz, inv_t ix, inv_t iy, inv_t iz);
    logic [CFG_W-1:0] vals [6];
    vals[0] = CFG_W'(sx);
    vals[1] = CFG_W'(sy);
    vals[2] = CFG_W'(sz);
    vals[3] = CFG_W'(ix);
    vals[4] = CFG_W'(iy);
    vals[5] = CFG_W'(iz);
    push_hold();
    for (int k = 0; k < 6; k++)
      push_step(STEP_REG, OP_LOAD, 0, 0, 0, '0, cfg_reg_t'(k), vals[k]);
    plan_n[0] = eff_size(sx, NX);
    plan_n[1] = eff_size(sy, NY);
    plan_n[2] = eff_size(sz, NZ);
    plan_settings++;
  endtask

  // mostly small grids, now and then large or out of range
  function automatic logic [SIZE_W-1:0] rand_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return SIZE_W'($urandom_range(6, 2));
    if (pick < 90) return SIZE_W'($urandom_range(32, 7));
    if (pick < 95) return SIZE_W'($urandom_range(1));
    return SIZE_W'($urandom_range(63, 33));
  endfunction

  function automatic inv_t rand_inv();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return INV_MAX;
    if (pick < 35) return INV_RST;
    return INV_W'($urandom_range(24'hFFFFFF));
  endfunction

  // ---- driver ----
  always @(posedge clk) begin
    plan_step_t s;
    logic nstart, nwe;
    nstart = start;
    nwe = 1'b0;
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      settle_cnt <= 0;
      for (int k = 0; k < 3; k++) begin
        size_reg[k] = SIZE_RST;
        inv_reg[k] = INV_RST;
      end
    end else begin
      // word taken at this edge
      if (start && !busy) begin
        apply_word(op_t'(opcode), x_index, y_index, z_index, cell_value);
        nstart = 1'b0;
      end
      if (!nstart && cmd_plan.size() > 0) begin
        s = cmd_plan[0];
        case (s.kind)
          STEP_WORD: begin
            if ($urandom_range(99) >= s.gap_pct) begin
              nstart = 1'b1;
              opcode <= s.op;
              x_index <= s.xi;
              y_index <= s.yi;
              z_index <= s.zi;
              cell_value <= s.val;
              void'(cmd_plan.pop_front());
            end
          end
          STEP_HOLD: begin
            if (busy || lap_pending.size() != 0) begin
              settle_cnt <= 0;
            end else if (settle_cnt < SETTLE_CYC) begin
              settle_cnt <= settle_cnt + 1;
            end else begin
              settle_cnt <= 0;
              void'(cmd_plan.pop_front());
            end
          end
          default: begin
            nwe = 1'b1;
            cfg_index <= s.ridx;
            cfg_data <= s.wdata;
            apply_reg(s.ridx, s.wdata);
            void'(cmd_plan.pop_front());
          end
        endcase
      end
      start <= nstart;
      cfg_we <= nwe;
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    lap_result_t want;
    if (!rst && done) begin
      if (lap_pending.size() == 0) begin
        n_fail++;
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: result word with none expected: laplacian %0d saturated %0b",
                   $realtime, laplacian, saturated);
      end else begin
        want = lap_pending.pop_front();
        n_checked++;
        if (laplacian !== want.lap) begin
          n_fail++;
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: laplacian mismatch: expected %0d, got %0d", $realtime,
                     $signed(want.lap), laplacian);
        end
        if (saturated !== want.sat) begin
          n_fail++;
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: saturated mismatch: expected %0b, got %0b", $realtime,
                     want.sat, saturated);
        end
      end
    end
  end

  // ---- stimulus plan, reset and end of run ----
  initial begin
    int target, pick, guard;
    n_loads = 0;
    n_queries = 0;
    n_checked = 0;
    n_cfg = 0;
    n_fail = 0;
    n_mismatch = 0;
    plan_gap = 9;
    plan_words = 0;
    plan_settings = 1;
    for (int k = 0; k < 3; k++) plan_n[k] = eff_size(SIZE_RST, axis_top(k));

    // directed: reset sizes, extreme values, stencils that wrap at both faces
    push_load(0, 0, 0, CELL_MIN);
    push_load(1, 0, 0, CELL_MAX);
    push_load(31, 0, 0, CELL_MAX);
    push_load(0, 1, 0, CELL_MAX);
    push_load(0, 31, 0, CELL_MAX);
    push_load(0, 0, 1, CELL_MAX);
    push_load(0, 0, 31, CELL_MAX);
    push_step(STEP_WORD, OP_QUERY, 0, 0, 0, CELL_MAX, REG_X_SIZE, '0);
    push_load(31, 31, 31, CELL_MAX);
    push_load(0, 31, 31, CELL_MIN);
    push_load(30, 31, 31, CELL_MIN);
    push_load(31, 0, 31, CELL_MIN);
    push_load(31, 30, 31, CELL_MIN);
    push_load(31, 31, 0, CELL_MIN);
    push_load(31, 31, 30, CELL_MIN);
    push_step(STEP_WORD, OP_QUERY, 31, 31, 31, CELL_MIN, REG_X_SIZE, '0);
    // sizes below 2 and above the maximum, indices far past the size
    push_cfg(0, 1, 63, '0, INV_MAX, 1);
    push_query(31, 31, 31);
    push_query(0, 0, 0);

    // random phases, each under its own register setting
    for (int p = 0; p < 6; p++) begin
      plan_gap = (p < 2) ? 9 : (p < 4) ? 64 : 0;
      case (p)
        0: push_cfg(2, 2, 2, '0, INV_MAX, 1);
        1: push_cfg(32, 32, 32, INV_MAX, INV_MAX, INV_MAX);
        default: push_cfg(rand_size(), rand_size(), rand_size(),
                          rand_inv(), rand_inv(), rand_inv());
      endcase
      target = plan_words + PHASE_WORDS;
      while (plan_words < target) begin
        pick = $urandom_range(99);
        if (pick < 60)
          push_query($urandom_range(IDX_TOP), $urandom_range(IDX_TOP),
                     $urandom_range(IDX_TOP));
        else if (pick < 96)
          push_load($urandom_range(IDX_TOP), $urandom_range(IDX_TOP),
                    $urandom_range(IDX_TOP), rand_cell());
        else
          push_hold();
      end
    end
    push_hold();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (cmd_plan.size() != 0) @(posedge clk);
    guard = 0;
    while (lap_pending.size() != 0 && guard < DRAIN_CYC) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYC) @(posedge clk);

    $display("Run covered %0d loads and %0d queries under %0d register settings",
             n_loads, n_queries, plan_settings);
    $display("(%0d register writes); %0d results checked, %0d mismatches, %0d left over.",
             n_cfg, n_checked, n_mismatch, lap_pending.size());
    if (n_fail == 0 && lap_pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d plan steps and %0d results still outstanding",
             cmd_plan.size(), lap_pending.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
src/pl3d_pkg.sv
src/pl3d_wrap.sv
src/pl3d_grid_ram.sv
src/pl3d_mac.sv
src/periodic_laplacian_3d_top.sv
bench/tb_periodic_laplacian_3d_top.sv
